// ===== rtl/mand_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Mandelbrot pixel engine.
// Depends on nothing; every other file in the block imports it.
package mand_pkg;

  // Number format and field widths.
  localparam int FRAC_BITS   = 24;
  localparam int DIM_BITS    = 12;
  localparam int VAL_BITS    = FRAC_BITS + 8;
  localparam int STEP_BITS   = 31;
  localparam int LIMIT_BITS  = 16;
  localparam int COUNT_BITS  = 16;
  localparam int BLUE_BITS   = 8;
  localparam int FRAME_BITS  = DIM_BITS + 1;
  localparam int CFG_DATA_BITS = STEP_BITS;
  localparam int CFG_IDX_BITS  = 2;

  // Multiplier operands must hold both a Q value and the pixel step.
  localparam int MUL_OP_BITS = (VAL_BITS > STEP_BITS) ? VAL_BITS : STEP_BITS + 1;
  localparam int PROD_BITS   = 2 * MUL_OP_BITS;

  // Reset values and escape radius.
  localparam int DEF_LIMIT    = 570;
  localparam int DEF_FRAME    = 1024;
  localparam int DEF_STEP     = 65536;
  localparam int ESC_RADIUS   = 2;

  typedef logic signed [VAL_BITS-1:0]    val_t;
  typedef logic signed [MUL_OP_BITS-1:0] mop_t;
  typedef logic        [MUL_OP_BITS-1:0] mag_t;
  typedef logic        [PROD_BITS-1:0]   prod_t;

  // Escape threshold |z|^2 >= R*R, one bit wider than a value.
  localparam logic signed [VAL_BITS:0] ESC_LEVEL =
    (VAL_BITS+1)'(ESC_RADIUS * ESC_RADIUS) << FRAC_BITS;

  // Saturation limits of a product magnitude.
  localparam prod_t MAG_LIM = PROD_BITS'(1) << (VAL_BITS - 1);
  localparam prod_t MAG_POS = MAG_LIM - PROD_BITS'(1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_PIXEL_STEP      = 2'd2,
    CFG_ITERATION_LIMIT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_width;
    logic [FRAME_BITS-1:0] frame_height;
    logic [STEP_BITS-1:0]  pixel_step;
    logic [LIMIT_BITS-1:0] iteration_limit;
  } cfg_t;

  // Right shift applied to a product before saturation.
  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_CROSS = 2'd1,
    SH_FRAC  = 2'd2
  } shift_sel_e;

  // One request to the shared multiplier.
  typedef struct packed {
    logic       en;
    mop_t       a;
    mop_t       b;
    shift_sel_e sh;
  } mul_req_t;

  // Shift a product magnitude, saturate it and apply the sign.
  function automatic val_t fx_scale(prod_t prod, logic neg, shift_sel_e sh);
    prod_t q;
    prod_t mag;
    case (sh)
      SH_NONE:  q = prod;
      SH_CROSS: q = prod >> (FRAC_BITS - 1);
      SH_FRAC:  q = prod >> FRAC_BITS;
      default:  q = prod;
    endcase
    if (neg) begin
      mag = (q > MAG_LIM) ? MAG_LIM : q;
      return val_t'(VAL_BITS'(0) - mag[VAL_BITS-1:0]);
    end
    mag = (q > MAG_POS) ? MAG_POS : q;
    return val_t'(mag[VAL_BITS-1:0]);
  endfunction

  // Exact sum of two values, saturated to the value range.
  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VAL_BITS:0] s;
    s = {a[VAL_BITS-1], a} + {b[VAL_BITS-1], b};
    if (s[VAL_BITS] != s[VAL_BITS-1]) begin
      return s[VAL_BITS] ? val_t'(MAG_LIM[VAL_BITS-1:0]) : val_t'(MAG_POS[VAL_BITS-1:0]);
    end
    return s[VAL_BITS-1:0];
  endfunction

  // Exact difference of two values, saturated to the value range.
  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [VAL_BITS:0] s;
    s = {a[VAL_BITS-1], a} - {b[VAL_BITS-1], b};
    if (s[VAL_BITS] != s[VAL_BITS-1]) begin
      return s[VAL_BITS] ? val_t'(MAG_LIM[VAL_BITS-1:0]) : val_t'(MAG_POS[VAL_BITS-1:0]);
    end
    return s[VAL_BITS-1:0];
  endfunction

endpackage

// ===== rtl/mand_pix_if.sv =====
// Pixel coordinate channel: valid/ready handshake with the pixel position.
// Depends on mand_pkg for the coordinate width.
interface mand_pix_if;
  import mand_pkg::*;

  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] pixel_x;
  logic [DIM_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/mand_res_if.sv =====
// Result channel: valid/ready handshake with iteration count, inside flag and blue byte.
// Depends on mand_pkg for the field widths.
interface mand_res_if;
  import mand_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;
  logic                  inside_set;
  logic [BLUE_BITS-1:0]  blue_level;

  modport source (output valid, output iteration_count, output inside_set,
                  output blue_level, input ready);
  modport sink   (input valid, input iteration_count, input inside_set,
                  input blue_level, output ready);
endinterface

// ===== rtl/mand_cfg.sv =====
// Configuration register bank of the Mandelbrot pixel engine.
// Depends on mand_pkg for the register layout and indexes.
module mand_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mand_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mand_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output mand_pkg::cfg_t                     cfg
);
  import mand_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Decode a write into the addressed register, truncated to its width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_FRAME_WIDTH:     cfg_nxt.frame_width     = cfg_data[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT:    cfg_nxt.frame_height    = cfg_data[FRAME_BITS-1:0];
        CFG_PIXEL_STEP:      cfg_nxt.pixel_step      = cfg_data[STEP_BITS-1:0];
        CFG_ITERATION_LIMIT: cfg_nxt.iteration_limit = cfg_data[LIMIT_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= FRAME_BITS'(DEF_FRAME);
      cfg_r.frame_height    <= FRAME_BITS'(DEF_FRAME);
      cfg_r.pixel_step      <= STEP_BITS'(DEF_STEP);
      cfg_r.iteration_limit <= LIMIT_BITS'(DEF_LIMIT);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mand_mul.sv =====
// Shared signed multiplier with a registered product and a saturating scaler.
// Depends on mand_pkg for operand types and the fx_scale helper.
module mand_mul (
  input  logic               clk,
  input  mand_pkg::mul_req_t req,
  output mand_pkg::val_t     res
);
  import mand_pkg::*;

  mag_t       a_mag, b_mag;
  prod_t      prod_r;
  logic       neg_r;
  shift_sel_e sh_r;

  // Operand magnitudes; the most negative code maps to its unsigned magnitude.
  assign a_mag = mag_t'(req.a[MUL_OP_BITS-1] ? -req.a : req.a);
  assign b_mag = mag_t'(req.b[MUL_OP_BITS-1] ? -req.b : req.b);

  // Full-width product, registered along with its sign and scaling.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_BITS'(a_mag) * PROD_BITS'(b_mag);
      neg_r  <= req.a[MUL_OP_BITS-1] ^ req.b[MUL_OP_BITS-1];
      sh_r   <= req.sh;
    end
  end

  // Shift, truncate the magnitude and saturate.
  assign res = fx_scale(prod_r, neg_r, sh_r);

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Top level of the Mandelbrot escape-time pixel engine: sequencer and iteration state.
// Depends on mand_pkg, mand_pix_if, mand_res_if, mand_cfg and mand_mul.
//
//   Channel   Direction  Handshake          Payload
//   in_pix    sink       valid/ready        pixel_x, pixel_y
//   out_res   source     valid/ready        iteration_count, inside_set, blue_level
//   cfg_*     input      cfg_we per cycle   cfg_index, cfg_data
//
// A pixel's result is formed over N iterations, where N is the iteration count: each
// iteration makes three passes through the one shared multiplier (cross term, zx
// squared, zy squared) plus an update and a test step. Mapping the pixel to c takes
// two more multiplier passes before the first iteration. The next pixel can be
// accepted in the cycle in which the result enters the output register. Reset is
// synchronous and active low; it restores the register defaults. in_pix.ready is
// high only while the sequencer is idle; a finished result waits in the output
// register, and a next result stalls until that one is taken.
module mandelbrot_escape_time_pixel (
  input  logic                               clk,
  input  logic                               rst_n,
  mand_pix_if.sink                           in_pix,
  mand_res_if.source                         out_res,
  input  logic                               cfg_we,
  input  logic [mand_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mand_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import mand_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MCX   = 10'b0000000010,
    S_MCY   = 10'b0000000100,
    S_CINIT = 10'b0000001000,
    S_MXY   = 10'b0000010000,
    S_UPD   = 10'b0000100000,
    S_MXX   = 10'b0001000000,
    S_MYY   = 10'b0010000000,
    S_CHK   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  cfg_t     cfg;
  mul_req_t mreq;
  val_t     mres;

  state_t                state_r, state_nxt;
  logic [DIM_BITS-1:0]   px_r, px_nxt, py_r, py_nxt;
  val_t                  cx_r, cx_nxt, cy_r, cy_nxt;
  val_t                  zx_r, zx_nxt, zy_r, zy_nxt;
  val_t                  zx2_r, zx2_nxt, zy2_r, zy2_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_inside_r, out_inside_nxt;
  logic [BLUE_BITS-1:0]  out_blue_r, out_blue_nxt;

  logic signed [DIM_BITS+1:0] dx, dy;
  logic signed [VAL_BITS:0]   mag_sum;
  logic                       run_on;
  logic                       in_acc, out_free, at_limit;

  mand_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mand_mul u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  // Offsets of the pixel from the frame center, halves taken by integer division.
  assign dx = $signed({2'b00, px_r}) - $signed({2'b00, cfg.frame_width[DIM_BITS:1]});
  assign dy = $signed({2'b00, py_r}) - $signed({2'b00, cfg.frame_height[DIM_BITS:1]});

  // Loop test: limit not reached and |z|^2 below the escape level.
  assign mag_sum = {zx2_r[VAL_BITS-1], zx2_r} + {zy2_r[VAL_BITS-1], zy2_r};
  assign run_on  = (count_r < cfg.iteration_limit) && (mag_sum < ESC_LEVEL);

  assign in_acc   = in_pix.valid && in_pix.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign at_limit = (count_r == cfg.iteration_limit);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt      = state_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    zx_nxt         = zx_r;
    zy_nxt         = zy_r;
    zx2_nxt        = zx2_r;
    zy2_nxt        = zy2_r;
    count_nxt      = count_r;
    out_count_nxt  = out_count_r;
    out_inside_nxt = out_inside_r;
    out_blue_nxt   = out_blue_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    mreq.en        = 1'b0;
    mreq.a         = mop_t'(zx_r);
    mreq.b         = mop_t'(zy_r);
    mreq.sh        = SH_CROSS;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          px_nxt    = in_pix.pixel_x;
          py_nxt    = in_pix.pixel_y;
          state_nxt = S_MCX;
        end
      end
      S_MCX: begin
        mreq.en   = 1'b1;
        mreq.a    = mop_t'(dx);
        mreq.b    = mop_t'(cfg.pixel_step);
        mreq.sh   = SH_NONE;
        state_nxt = S_MCY;
      end
      S_MCY: begin
        cx_nxt    = mres;
        mreq.en   = 1'b1;
        mreq.a    = mop_t'(dy);
        mreq.b    = mop_t'(cfg.pixel_step);
        mreq.sh   = SH_NONE;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cy_nxt    = mres;
        zx_nxt    = '0;
        zy_nxt    = '0;
        zx2_nxt   = '0;
        zy2_nxt   = '0;
        count_nxt = '0;
        state_nxt = S_MXY;
      end
      S_MXY: begin
        if (run_on) begin
          mreq.en   = 1'b1;
          mreq.a    = mop_t'(zx_r);
          mreq.b    = mop_t'(zy_r);
          mreq.sh   = SH_CROSS;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UPD: begin
        zy_nxt    = sat_add(mres, cy_r);
        zx_nxt    = sat_add(sat_sub(zx2_r, zy2_r), cx_r);
        state_nxt = S_MXX;
      end
      S_MXX: begin
        mreq.en   = 1'b1;
        mreq.a    = mop_t'(zx_r);
        mreq.b    = mop_t'(zx_r);
        mreq.sh   = SH_FRAC;
        state_nxt = S_MYY;
      end
      S_MYY: begin
        zx2_nxt   = mres;
        mreq.en   = 1'b1;
        mreq.a    = mop_t'(zy_r);
        mreq.b    = mop_t'(zy_r);
        mreq.sh   = SH_FRAC;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        zy2_nxt   = mres;
        count_nxt = count_r + COUNT_BITS'(1);
        state_nxt = S_MXY;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = count_r;
          out_inside_nxt = at_limit;
          out_blue_nxt   = at_limit ? '0 : count_r[BLUE_BITS-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and iteration registers.
  always_ff @(posedge clk) begin
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    zx_r         <= zx_nxt;
    zy_r         <= zy_nxt;
    zx2_r        <= zx2_nxt;
    zy2_r        <= zy2_nxt;
    count_r      <= count_nxt;
    out_count_r  <= out_count_nxt;
    out_inside_r <= out_inside_nxt;
    out_blue_r   <= out_blue_nxt;
  end

  assign in_pix.ready            = (state_r == S_IDLE);
  assign out_res.valid           = out_valid_r;
  assign out_res.iteration_count = out_count_r;
  assign out_res.inside_set      = out_inside_r;
  assign out_res.blue_level      = out_blue_r;

  // An accepted pixel always starts the mapping of c.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MCX))
    else $error("accepted pixel did not start mapping");

  // An iteration only runs while the count is below the limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (count_r < cfg.iteration_limit))
    else $error("iteration ran past the limit");

  // The count steps by one at the end of each iteration.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |=> (count_r == COUNT_BITS'($past(count_r) + COUNT_BITS'(1))))
    else $error("iteration count did not step by one");

  // Finishing a pixel loads the output register and frees the input.
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_free) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finished pixel did not reach the output register");

endmodule

// ===== bench/tb_mandelbrot_escape_time_pixel.sv =====
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
// Uses mand_pkg and the pixel and result channel interfaces. It predicts
// every result in fixed point and checks each returned transaction in order.
module tb_mandelbrot_escape_time_pixel;
  timeunit 1ns;
  timeprecision 1ps;
  import mand_pkg::*;

  // Q8.24 value range and escape threshold for the predictor.
  localparam longint Q_MAX = (longint'(1) << (VAL_BITS - 1)) - 1;
  localparam longint Q_LIM = longint'(1) << (VAL_BITS - 1);
  localparam longint ESC_Q = longint'(ESC_RADIUS * ESC_RADIUS) << FRAC_BITS;

  localparam int          HOLD_CYCLES = 3000;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int          PHASES      = 9;

  typedef struct packed {
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  in_set;
    logic [BLUE_BITS-1:0]  blue;
  } escape_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  mand_pix_if in_pix();
  mand_res_if out_res();

  mandelbrot_escape_time_pixel u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Register values as the block holds them, pixels still to be sent,
  // and the escape results expected back in order.
  cfg_t        view_cfg;
  pixel_t      pixel_backlog[$];
  escape_t     pending_escapes[$];
  int          fail_count;
  int          gap_left;
  int          stall_left;
  int          hold_left;
  logic        hold_start;
  logic        steady;
  int unsigned cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= 100) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  // Saturate an exact value to the Q8.24 range.
  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < -Q_LIM) return -Q_LIM;
    return v;
  endfunction

  // Full-width product, magnitude shifted right, then saturated.
  function automatic longint q_product(longint a, longint b, int sh);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned q;
    logic            neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = (ma * mb) >> sh;
    if (neg) return (q > Q_LIM) ? -Q_LIM : -longint'(q);
    return (q > Q_MAX) ? Q_MAX : longint'(q);
  endfunction

  // Pixel offset from the frame center, scaled by the step.
  function automatic longint map_axis(logic [DIM_BITS-1:0] pix, logic [FRAME_BITS-1:0] size,
                                      logic [STEP_BITS-1:0] step);
    longint offset;
    offset = longint'(pix) - longint'(size >> 1);
    return clamp_q(offset * longint'(step));
  endfunction

  // Iterate z = z*z + c from zero and form the escape result.
  function automatic escape_t escape_time(pixel_t p, cfg_t c);
    longint  cx;
    longint  cy;
    longint  zx;
    longint  zy;
    longint  zx2;
    longint  zy2;
    int      count;
    escape_t r;
    cx = map_axis(p.x, c.frame_width, c.pixel_step);
    cy = map_axis(p.y, c.frame_height, c.pixel_step);
    zx = 0;
    zy = 0;
    zx2 = 0;
    zy2 = 0;
    count = 0;
    while (count < int'(c.iteration_limit) && zx2 + zy2 < ESC_Q) begin
      zy = clamp_q(q_product(zx, zy, FRAC_BITS - 1) + cy);
      zx = clamp_q(clamp_q(zx2 - zy2) + cx);
      zx2 = q_product(zx, zx, FRAC_BITS);
      zy2 = q_product(zy, zy, FRAC_BITS);
      count++;
    end
    r.count = count[COUNT_BITS-1:0];
    r.in_set = (count == int'(c.iteration_limit));
    r.blue = r.in_set ? '0 : count[BLUE_BITS-1:0];
    return r;
  endfunction

  // Pixel driver: offers queued pixels, predicts each accepted transaction.
  always @(posedge clk) begin : pixel_driver
    pixel_t seen;
    pixel_t next_pix;
    logic   free;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
      gap_left <= 0;
    end else begin
      free = !in_pix.valid;
      if (in_pix.valid && in_pix.ready) begin
        seen.x = in_pix.pixel_x;
        seen.y = in_pix.pixel_y;
        pending_escapes.push_back(escape_time(seen, view_cfg));
        free = 1'b1;
      end
      if (free) begin
        if (gap_left != 0) begin
          in_pix.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_backlog.size() != 0) begin
          next_pix = pixel_backlog.pop_front();
          in_pix.pixel_x <= next_pix.x;
          in_pix.pixel_y <= next_pix.y;
          in_pix.valid <= 1'b1;
          gap_left <= steady ? 0 : $urandom_range(0, 17);
        end else begin
          in_pix.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk) begin : ready_hold
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each accepted transaction and paces ready.
  always @(posedge clk) begin : result_monitor
    escape_t want;
    int      wait_n;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      wait_n = stall_left;
      if (out_res.valid && out_res.ready) begin
        if (pending_escapes.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, count %0d",
                                    out_res.iteration_count));
        end else begin
          want = pending_escapes.pop_front();
          if (out_res.iteration_count !== want.count) begin
            report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                      out_res.iteration_count, want.count));
          end
          if (out_res.inside_set !== want.in_set) begin
            report_mismatch($sformatf("inside_set %0b, expected %0b",
                                      out_res.inside_set, want.in_set));
          end
          if (out_res.blue_level !== want.blue) begin
            report_mismatch($sformatf("blue_level %0d, expected %0d",
                                      out_res.blue_level, want.blue));
          end
        end
        wait_n = steady ? 0 : $urandom_range(0, 17);
      end else if (wait_n != 0) begin
        wait_n--;
      end
      stall_left <= wait_n;
      out_res.ready <= (wait_n == 0) && (hold_left == 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[mandelbrot_escape_time_pixel] ERROR");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(int w, int h, longint step, int lim);
    cfg_t c;
    c.frame_width = w[FRAME_BITS-1:0];
    c.frame_height = h[FRAME_BITS-1:0];
    c.pixel_step = step[STEP_BITS-1:0];
    c.iteration_limit = lim[LIMIT_BITS-1:0];
    return c;
  endfunction

  // One register write; the mirror follows since the block is idle.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_FRAME_WIDTH:     view_cfg.frame_width = data[FRAME_BITS-1:0];
      CFG_FRAME_HEIGHT:    view_cfg.frame_height = data[FRAME_BITS-1:0];
      CFG_PIXEL_STEP:      view_cfg.pixel_step = data[STEP_BITS-1:0];
      CFG_ITERATION_LIMIT: view_cfg.iteration_limit = data[LIMIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(cfg_t c);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(c.frame_width));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(c.frame_height));
    write_reg(CFG_PIXEL_STEP, CFG_DATA_BITS'(c.pixel_step));
    write_reg(CFG_ITERATION_LIMIT, CFG_DATA_BITS'(c.iteration_limit));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = x[DIM_BITS-1:0];
    p.y = y[DIM_BITS-1:0];
    pixel_backlog.push_back(p);
  endtask

  // Wait until every pixel is sent and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_pix.valid || pending_escapes.size() != 0);
  endtask

  function automatic logic [FRAME_BITS-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FRAME_BITS'(1);
      2: return FRAME_BITS'($urandom);
      default: return FRAME_BITS'($urandom_range(1, 4096));
    endcase
  endfunction

  // Mostly inside the frame, sometimes anywhere in the coordinate range.
  function automatic int pick_coord(logic [FRAME_BITS-1:0] size);
    if (size == 0 || size > (1 << DIM_BITS) || $urandom_range(0, 99) < 15) begin
      return $urandom_range(0, (1 << DIM_BITS) - 1);
    end
    return $urandom_range(0, int'(size) - 1);
  endfunction

  // Random setting; the step is usually scaled so the frame spans the set.
  function automatic cfg_t draw_setting();
    cfg_t   c;
    int     span;
    int     pick;
    longint step;
    c.frame_width = pick_size();
    c.frame_height = pick_size();
    span = (c.frame_width > c.frame_height) ? int'(c.frame_width) : int'(c.frame_height);
    if (span == 0) span = 1;
    pick = $urandom_range(0, 19);
    if (pick == 0) step = 0;
    else if (pick < 4) step = longint'($urandom) & Q_MAX;
    else if (pick < 7) step = longint'($urandom_range(1, 1 << 16));
    else step = longint'($urandom_range(2 << FRAC_BITS, 6 << FRAC_BITS)) / span;
    c.pixel_step = step[STEP_BITS-1:0];
    pick = $urandom_range(0, 19);
    if (pick < 12) c.iteration_limit = LIMIT_BITS'($urandom_range(1, 40));
    else if (pick < 17) c.iteration_limit = LIMIT_BITS'($urandom_range(41, 255));
    else if (pick < 19) c.iteration_limit = LIMIT_BITS'($urandom_range(256, 600));
    else c.iteration_limit = LIMIT_BITS'($urandom_range(0, 1));
    return c;
  endfunction

  // Main sequence: reset, directed pixels, then random phases.
  initial begin : main_sequence
    cfg_t setting;
    int   n_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    in_pix.valid = 1'b0;
    in_pix.pixel_x = '0;
    in_pix.pixel_y = '0;
    out_res.ready = 1'b0;
    hold_start = 1'b0;
    steady = 1'b0;
    fail_count = 0;
    cycles = 0;
    hold_left = 0;
    view_cfg = make_cfg(DEF_FRAME, DEF_FRAME, DEF_STEP, DEF_LIMIT);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: the center stays inside, the corners escape at once.
    queue_pixel(512, 512);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    queue_pixel(520, 500);
    drain();

    // Zero frame size with a zero iteration limit.
    apply_setting(make_cfg(0, 0, longint'(1) << FRAC_BITS, 0));
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // Zero step puts every pixel at the origin.
    apply_setting(make_cfg(4096, 4096, 0, 20));
    queue_pixel(0, 4095);
    queue_pixel(4095, 0);
    drain();

    // Largest step and limit: c saturates, so pixels off center escape.
    apply_setting(make_cfg(4096, 4096, Q_MAX, 65535));
    queue_pixel(0, 0);
    queue_pixel(4095, 2048);
    queue_pixel(2049, 2048);
    queue_pixel(2047, 2049);
    queue_pixel(2048, 0);
    drain();

    // Widest frame register value with a one-pixel-high frame.
    apply_setting(make_cfg(8191, 1, 24576, 300));
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(2000, 4095);
    queue_pixel(3000, 1);
    drain();

    // Random phases, each under a fresh setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph % 3 == 2);
      setting = draw_setting();
      if (ph == 1) setting.iteration_limit = LIMIT_BITS'($urandom_range(4, 24));
      apply_setting(setting);
      n_items = (setting.iteration_limit > 255) ? 30 : 125;
      for (int i = 0; i < n_items; i++) begin
        queue_pixel(pick_coord(setting.frame_width), pick_coord(setting.frame_height));
      end
      // Hold the result side off so the engine backs up into its input.
      if (ph == 1) begin
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      drain();
    end

    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("[mandelbrot_escape_time_pixel] OK");
    end else begin
      $display("[mandelbrot_escape_time_pixel] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mand_pkg.sv
rtl/mand_pix_if.sv
rtl/mand_res_if.sv
rtl/mand_cfg.sv
rtl/mand_mul.sv
rtl/mandelbrot_escape_time_pixel.sv
bench/tb_mandelbrot_escape_time_pixel.sv
